// ===== src/assert_macros.svh =====
// Assertion macros shared by the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/mpm_pkg.sv =====
// Package with types and constants of the multi-pattern matcher.
package mpm_pkg;

   // Operation codes carried in the request side band.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_SCAN = 1'b1;

   // At most this many results are reported for one scanned symbol.
   localparam int OUT_CAP = 64;

   // ASCII lower-case range and the distance to upper case.
   localparam logic [15:0] LOWER_A    = 16'h0061;
   localparam logic [15:0] LOWER_Z    = 16'h007A;
   localparam logic [15:0] CASE_DELTA = 16'h0020;

   // Request side band, lowest bit first: op, then first_symbol.
   typedef struct packed {
      logic first_symbol;
      logic op;
   } req_user_type;

endpackage

// ===== src/multi_pattern_matcher.sv =====
// Aho-Corasick multi-pattern matcher built around a goto-table memory.
`include "assert_macros.svh"

// Multi-pattern matcher. Transfers with op=load append one symbol to the pattern being
// loaded; last_symbol (tlast) closes the pattern and records its id, unless the id is
// already in use, the trie ran out of nodes, or all pattern slots are taken. Transfers with
// op=scan feed one haystack symbol; first_symbol restarts at the root and forgets the ids
// found so far. Every id newly found in the current haystack is reported once, deepest
// match first and, within one node, in load order, with tlast on the final result of the
// symbol; at most 64 results per symbol. The fold_case register upper-cases ASCII letters
// of both patterns and haystack and must be written only while the block is idle.
// After reset the block sweeps its memories before it takes its first transfer. A load
// reads the goto-table, then updates it. A scan follows failure links until a goto
// transition exists, then walks the output chain and examines every pattern slot at each
// terminal node; a first_symbol first forgets the ids found in the previous haystack, one
// after another. A result that the receiver does not take stalls the scan until it does.
// The first scan after any load also rebuilds the failure links by a breadth-first pass
// that reads the goto-table once per node and symbol. Each memory has a single read port
// with registered read data.
module multi_pattern_matcher #(
   parameter int NODES        = 256,
   parameter int SYMBOL_BITS  = 8,
   parameter int MAX_PATTERNS = 64,
   parameter int ID_BITS      = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // symbol [7:0], pattern_id [15:8]
   input  logic                  req_tlast,   // last_symbol
   input  mpm_pkg::req_user_type req_tuser,   // op [0], first_symbol [1]
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // match_id [7:0]
   output logic                  rsp_tlast,   // last_match
   // Configuration: fold_case.
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);
   import mpm_pkg::*;

   localparam int NB          = $clog2(NODES);
   localparam int SB          = SYMBOL_BITS;
   localparam int IDB         = ID_BITS;
   localparam int GOTO_ABITS  = NB + SB;
   localparam int GOTO_DEPTH  = 1 << GOTO_ABITS;
   localparam int ID_DEPTH    = 1 << IDB;
   localparam int SLOT_AW     = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
   localparam int SCW         = $clog2(MAX_PATTERNS + 1);
   localparam int CLR_BITS    = (GOTO_ABITS > IDB) ? GOTO_ABITS : IDB;
   localparam int NCW         = NB + 1;
   localparam int NW          = $clog2(OUT_CAP + 1);
   localparam logic [15:0] SYM_MASK = 16'((32'd1 << SB) - 32'd1);

   // Sequencer states.
   localparam logic [4:0] S_CLEAR   = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_LOAD    = 5'd2;
   localparam logic [4:0] S_FC_RD   = 5'd3;
   localparam logic [4:0] S_FC_WR   = 5'd4;
   localparam logic [4:0] S_B_INIT  = 5'd5;
   localparam logic [4:0] S_B_POP   = 5'd6;
   localparam logic [4:0] S_B_U     = 5'd7;
   localparam logic [4:0] S_B_FU    = 5'd8;
   localparam logic [4:0] S_B_C     = 5'd9;
   localparam logic [4:0] S_B_CV    = 5'd10;
   localparam logic [4:0] S_B_F     = 5'd11;
   localparam logic [4:0] S_B_FV    = 5'd12;
   localparam logic [4:0] S_B_FF    = 5'd13;
   localparam logic [4:0] S_STEP_RD = 5'd14;
   localparam logic [4:0] S_STEP_EV = 5'd15;
   localparam logic [4:0] S_T_RD    = 5'd16;
   localparam logic [4:0] S_T_EV    = 5'd17;
   localparam logic [4:0] S_K_RD    = 5'd18;
   localparam logic [4:0] S_K_EV    = 5'd19;
   localparam logic [4:0] S_K_FD    = 5'd20;
   localparam logic [4:0] S_FIN     = 5'd21;

   // Memories.
   logic [NB-1:0]       goto_mem  [GOTO_DEPTH];
   logic [NB-1:0]       fail_mem  [NODES];
   logic                term_mem  [NODES];
   logic [NB+IDB-1:0]   slot_mem  [MAX_PATTERNS];
   logic                found_mem [ID_DEPTH];
   logic [IDB-1:0]      flist_mem [MAX_PATTERNS];
   logic                used_mem  [ID_DEPTH];
   logic [NB-1:0]       queue_mem [NODES];

   // Memory port controls.
   logic                  goto_we, goto_re;
   logic [GOTO_ABITS-1:0] goto_wa, goto_ra;
   logic [NB-1:0]         goto_wd, goto_rd_ff;
   logic                  fail_we, fail_re;
   logic [NB-1:0]         fail_wa, fail_ra, fail_wd, fail_rd_ff;
   logic                  term_we, term_re, term_wd, term_rd_ff;
   logic [NB-1:0]         term_wa, term_ra;
   logic                  slot_we, slot_re;
   logic [SLOT_AW-1:0]    slot_wa, slot_ra;
   logic [NB+IDB-1:0]     slot_wd, slot_rd_ff;
   logic                  found_we, found_re, found_wd, found_rd_ff;
   logic [IDB-1:0]        found_wa, found_ra;
   logic                  flist_we, flist_re;
   logic [SLOT_AW-1:0]    flist_wa, flist_ra;
   logic [IDB-1:0]        flist_wd, flist_rd_ff;
   logic                  used_we, used_re, used_wd, used_rd_ff;
   logic [IDB-1:0]        used_wa, used_ra;
   logic                  queue_we, queue_re;
   logic [NB-1:0]         queue_wa, queue_ra, queue_wd, queue_rd_ff;

   // Control and payload registers.
   logic [4:0]          state_ff, state_in;
   logic [CLR_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic                fold_ff;
   logic [SB-1:0]       sym_ff, sym_in;
   logic [IDB-1:0]      id_ff, id_in;
   logic                last_ff, last_in;
   logic [NCW-1:0]      node_count_ff, node_count_in;
   logic [SCW-1:0]      slot_count_ff, slot_count_in;
   logic [NB-1:0]       load_node_ff, load_node_in;
   logic                dropped_ff, dropped_in;
   logic                links_valid_ff, links_valid_in;
   logic [NB-1:0]       cur_ff, cur_in;
   logic [SCW-1:0]      fcnt_ff, fcnt_in;
   logic [SCW-1:0]      fidx_ff, fidx_in;
   logic [NB-1:0]       node_ff, node_in;
   logic [NB-1:0]       t_ff, t_in;
   logic [NB-1:0]       tnext_ff, tnext_in;
   logic [SCW-1:0]      k_ff, k_in;
   logic [IDB-1:0]      sid_ff, sid_in;
   logic [NW-1:0]       n_ff, n_in;
   logic                pend_v_ff, pend_v_in;
   logic [IDB-1:0]      pend_id_ff, pend_id_in;
   logic [NCW-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [NB-1:0]       u_ff, u_in, fu_ff, fu_in, f_ff, f_in, v_ff, v_in;
   logic [SB-1:0]       bs_ff, bs_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_id_ff, rsp_id_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_fire, out_free;
   logic [15:0]         sym_wide, sym_folded;
   logic [NB-1:0]       nxt_node;
   logic                drop_now;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The symbol is reduced to the symbol width, then optionally upper-cased.
   always_comb begin
      sym_wide   = 16'(req_tdata[7:0]) & SYM_MASK;
      sym_folded = sym_wide;
      if (fold_ff && sym_wide >= LOWER_A && sym_wide <= LOWER_Z) begin
         sym_folded = sym_wide - CASE_DELTA;
      end
   end

   // Main sequencer: every memory access and state update is decided here.
   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      sym_in         = sym_ff;
      id_in          = id_ff;
      last_in        = last_ff;
      node_count_in  = node_count_ff;
      slot_count_in  = slot_count_ff;
      load_node_in   = load_node_ff;
      dropped_in     = dropped_ff;
      links_valid_in = links_valid_ff;
      cur_in         = cur_ff;
      fcnt_in        = fcnt_ff;
      fidx_in        = fidx_ff;
      node_in        = node_ff;
      t_in           = t_ff;
      tnext_in       = tnext_ff;
      k_in           = k_ff;
      sid_in         = sid_ff;
      n_in           = n_ff;
      pend_v_in      = pend_v_ff;
      pend_id_in     = pend_id_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      u_in           = u_ff;
      fu_in          = fu_ff;
      f_in           = f_ff;
      v_in           = v_ff;
      bs_in          = bs_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_id_in      = rsp_id_ff;
      rsp_last_in    = rsp_last_ff;
      nxt_node       = goto_rd_ff;
      drop_now       = dropped_ff;

      goto_we  = 1'b0; goto_wa  = '0; goto_wd  = '0; goto_re  = 1'b0; goto_ra  = '0;
      fail_we  = 1'b0; fail_wa  = '0; fail_wd  = '0; fail_re  = 1'b0; fail_ra  = '0;
      term_we  = 1'b0; term_wa  = '0; term_wd  = 1'b0; term_re = 1'b0; term_ra  = '0;
      slot_we  = 1'b0; slot_wa  = '0; slot_wd  = '0; slot_re  = 1'b0; slot_ra  = '0;
      found_we = 1'b0; found_wa = '0; found_wd = 1'b0; found_re = 1'b0; found_ra = '0;
      flist_we = 1'b0; flist_wa = '0; flist_wd = '0; flist_re = 1'b0; flist_ra = '0;
      used_we  = 1'b0; used_wa  = '0; used_wd  = 1'b0; used_re = 1'b0; used_ra  = '0;
      queue_we = 1'b0; queue_wa = '0; queue_wd = '0; queue_re = 1'b0; queue_ra = '0;

      unique case (state_ff)
         S_CLEAR: begin
            goto_we  = 1'b1;
            goto_wa  = clr_cnt_ff[GOTO_ABITS-1:0];
            term_we  = (32'(clr_cnt_ff[NB-1:0]) < NODES);
            term_wa  = clr_cnt_ff[NB-1:0];
            found_we = 1'b1;
            found_wa = clr_cnt_ff[IDB-1:0];
            used_we  = 1'b1;
            used_wa  = clr_cnt_ff[IDB-1:0];
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               sym_in  = SB'(sym_folded);
               id_in   = IDB'(16'(req_tdata[15:8]));
               last_in = req_tlast;
               n_in    = '0;
               if (req_tuser.op == OP_LOAD) begin
                  links_valid_in = 1'b0;
                  goto_re  = 1'b1;
                  goto_ra  = {load_node_ff, SB'(sym_folded)};
                  used_re  = 1'b1;
                  used_ra  = IDB'(16'(req_tdata[15:8]));
                  state_in = S_LOAD;
               end else if (req_tuser.first_symbol) begin
                  fidx_in  = '0;
                  cur_in   = '0;
                  node_in  = '0;
                  state_in = S_FC_RD;
               end else begin
                  node_in  = cur_ff;
                  state_in = links_valid_ff ? S_STEP_RD : S_B_INIT;
               end
            end
         end
         S_LOAD: begin
            if (!dropped_ff && goto_rd_ff == '0) begin
               if (node_count_ff < NCW'(NODES)) begin
                  nxt_node      = node_count_ff[NB-1:0];
                  goto_we       = 1'b1;
                  goto_wa       = {load_node_ff, sym_ff};
                  goto_wd       = node_count_ff[NB-1:0];
                  node_count_in = node_count_ff + 1'b1;
               end else begin
                  drop_now = 1'b1;
               end
            end
            if (last_ff) begin
               if (!drop_now && !used_rd_ff && slot_count_ff < SCW'(MAX_PATTERNS)) begin
                  used_we  = 1'b1;
                  used_wa  = id_ff;
                  used_wd  = 1'b1;
                  term_we  = 1'b1;
                  term_wa  = nxt_node;
                  term_wd  = 1'b1;
                  slot_we  = 1'b1;
                  slot_wa  = slot_count_ff[SLOT_AW-1:0];
                  slot_wd  = {nxt_node, id_ff};
                  slot_count_in = slot_count_ff + 1'b1;
               end
               dropped_in   = 1'b0;
               load_node_in = '0;
            end else begin
               dropped_in = drop_now;
               if (!drop_now) begin
                  load_node_in = nxt_node;
               end
            end
            state_in = S_IDLE;
         end
         // Forget the ids found in the previous haystack, one after another.
         S_FC_RD: begin
            if (fidx_ff == fcnt_ff) begin
               fcnt_in  = '0;
               state_in = links_valid_ff ? S_STEP_RD : S_B_INIT;
            end else begin
               flist_re = 1'b1;
               flist_ra = fidx_ff[SLOT_AW-1:0];
               state_in = S_FC_WR;
            end
         end
         S_FC_WR: begin
            found_we = 1'b1;
            found_wa = flist_rd_ff;
            found_wd = 1'b0;
            fidx_in  = fidx_ff + 1'b1;
            state_in = S_FC_RD;
         end
         // Breadth-first construction of the failure links.
         S_B_INIT: begin
            queue_we = 1'b1;
            queue_wa = '0;
            queue_wd = '0;
            head_in  = '0;
            tail_in  = NCW'(1);
            state_in = S_B_POP;
         end
         S_B_POP: begin
            if (head_ff == tail_ff) begin
               links_valid_in = 1'b1;
               state_in = S_STEP_RD;
            end else begin
               queue_re = 1'b1;
               queue_ra = head_ff[NB-1:0];
               head_in  = head_ff + 1'b1;
               state_in = S_B_U;
            end
         end
         S_B_U: begin
            u_in     = queue_rd_ff;
            fail_re  = 1'b1;
            fail_ra  = queue_rd_ff;
            state_in = S_B_FU;
         end
         S_B_FU: begin
            fu_in    = fail_rd_ff;
            bs_in    = '0;
            state_in = S_B_C;
         end
         S_B_C: begin
            goto_re  = 1'b1;
            goto_ra  = {u_ff, bs_ff};
            state_in = S_B_CV;
         end
         S_B_CV: begin
            v_in = goto_rd_ff;
            if (goto_rd_ff == '0) begin
               bs_in    = bs_ff + 1'b1;
               state_in = (&bs_ff) ? S_B_POP : S_B_C;
            end else if (u_ff == '0) begin
               // Children of the root fall back to the root.
               fail_we  = 1'b1;
               fail_wa  = goto_rd_ff;
               fail_wd  = '0;
               queue_we = 1'b1;
               queue_wa = tail_ff[NB-1:0];
               queue_wd = goto_rd_ff;
               tail_in  = tail_ff + 1'b1;
               bs_in    = bs_ff + 1'b1;
               state_in = (&bs_ff) ? S_B_POP : S_B_C;
            end else begin
               f_in     = fu_ff;
               state_in = S_B_F;
            end
         end
         S_B_F: begin
            goto_re  = 1'b1;
            goto_ra  = {f_ff, bs_ff};
            state_in = S_B_FV;
         end
         S_B_FV: begin
            if (f_ff == '0 || goto_rd_ff != '0) begin
               fail_we  = 1'b1;
               fail_wa  = v_ff;
               fail_wd  = goto_rd_ff;
               queue_we = 1'b1;
               queue_wa = tail_ff[NB-1:0];
               queue_wd = v_ff;
               tail_in  = tail_ff + 1'b1;
               bs_in    = bs_ff + 1'b1;
               state_in = (&bs_ff) ? S_B_POP : S_B_C;
            end else begin
               fail_re  = 1'b1;
               fail_ra  = f_ff;
               state_in = S_B_FF;
            end
         end
         S_B_FF: begin
            f_in     = fail_rd_ff;
            state_in = S_B_F;
         end
         // Goto transition, falling back along failure links.
         S_STEP_RD: begin
            goto_re  = 1'b1;
            goto_ra  = {node_ff, sym_ff};
            fail_re  = 1'b1;
            fail_ra  = node_ff;
            state_in = S_STEP_EV;
         end
         S_STEP_EV: begin
            if (node_ff == '0 || goto_rd_ff != '0) begin
               node_in  = goto_rd_ff;
               cur_in   = goto_rd_ff;
               t_in     = goto_rd_ff;
               state_in = S_T_RD;
            end else begin
               node_in  = fail_rd_ff;
               state_in = S_STEP_RD;
            end
         end
         // Walk of the output chain.
         S_T_RD: begin
            if (t_ff == '0) begin
               state_in = S_FIN;
            end else begin
               term_re  = 1'b1;
               term_ra  = t_ff;
               fail_re  = 1'b1;
               fail_ra  = t_ff;
               state_in = S_T_EV;
            end
         end
         S_T_EV: begin
            if (term_rd_ff) begin
               tnext_in = fail_rd_ff;
               k_in     = '0;
               state_in = S_K_RD;
            end else begin
               t_in     = fail_rd_ff;
               state_in = S_T_RD;
            end
         end
         S_K_RD: begin
            if (n_ff == NW'(OUT_CAP)) begin
               state_in = S_FIN;
            end else if (k_ff == slot_count_ff) begin
               t_in     = tnext_ff;
               state_in = S_T_RD;
            end else begin
               slot_re  = 1'b1;
               slot_ra  = k_ff[SLOT_AW-1:0];
               state_in = S_K_EV;
            end
         end
         S_K_EV: begin
            if (slot_rd_ff[NB+IDB-1:IDB] == t_ff) begin
               sid_in   = slot_rd_ff[IDB-1:0];
               found_re = 1'b1;
               found_ra = slot_rd_ff[IDB-1:0];
               state_in = S_K_FD;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_K_RD;
            end
         end
         S_K_FD: begin
            if (found_rd_ff) begin
               k_in     = k_ff + 1'b1;
               state_in = S_K_RD;
            end else if (!pend_v_ff || out_free) begin
               // The previous match goes out now; this one waits to learn whether it is last.
               found_we = 1'b1;
               found_wa = sid_ff;
               found_wd = 1'b1;
               flist_we = 1'b1;
               flist_wa = fcnt_ff[SLOT_AW-1:0];
               flist_wd = sid_ff;
               fcnt_in  = fcnt_ff + 1'b1;
               if (pend_v_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = 8'(pend_id_ff);
                  rsp_last_in  = 1'b0;
               end
               pend_v_in  = 1'b1;
               pend_id_in = sid_ff;
               n_in       = n_ff + 1'b1;
               k_in       = k_ff + 1'b1;
               state_in   = S_K_RD;
            end
         end
         S_FIN: begin
            if (!pend_v_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = 8'(pend_id_ff);
               rsp_last_in  = 1'b1;
               pend_v_in    = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_cnt_ff     <= '0;
         fold_ff        <= 1'b0;
         node_count_ff  <= NCW'(1);
         slot_count_ff  <= '0;
         load_node_ff   <= '0;
         dropped_ff     <= 1'b0;
         links_valid_ff <= 1'b0;
         cur_ff         <= '0;
         fcnt_ff        <= '0;
         pend_v_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         n_ff           <= '0;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         if (csr_wr_en) begin
            fold_ff <= csr_wr_data;
         end
         node_count_ff  <= node_count_in;
         slot_count_ff  <= slot_count_in;
         load_node_ff   <= load_node_in;
         dropped_ff     <= dropped_in;
         links_valid_ff <= links_valid_in;
         cur_ff         <= cur_in;
         fcnt_ff        <= fcnt_in;
         pend_v_ff      <= pend_v_in;
         rsp_valid_ff   <= rsp_valid_in;
         n_ff           <= n_in;
      end
   end

   // Payload and walk registers.
   always_ff @(posedge clock) begin
      sym_ff     <= sym_in;
      id_ff      <= id_in;
      last_ff    <= last_in;
      fidx_ff    <= fidx_in;
      node_ff    <= node_in;
      t_ff       <= t_in;
      tnext_ff   <= tnext_in;
      k_ff       <= k_in;
      sid_ff     <= sid_in;
      pend_id_ff <= pend_id_in;
      head_ff    <= head_in;
      tail_ff    <= tail_in;
      u_ff       <= u_in;
      fu_ff      <= fu_in;
      f_ff       <= f_in;
      v_ff       <= v_in;
      bs_ff      <= bs_in;
      rsp_id_ff  <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Memories: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (goto_we) goto_mem[goto_wa] <= goto_wd;
      if (goto_re) goto_rd_ff <= goto_mem[goto_ra];
   end

   always_ff @(posedge clock) begin
      if (fail_we) fail_mem[fail_wa] <= fail_wd;
      if (fail_re) fail_rd_ff <= fail_mem[fail_ra];
   end

   always_ff @(posedge clock) begin
      if (term_we) term_mem[term_wa] <= term_wd;
      if (term_re) term_rd_ff <= term_mem[term_ra];
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      if (slot_re) slot_rd_ff <= slot_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (found_we) found_mem[found_wa] <= found_wd;
      if (found_re) found_rd_ff <= found_mem[found_ra];
   end

   always_ff @(posedge clock) begin
      if (flist_we) flist_mem[flist_wa] <= flist_wd;
      if (flist_re) flist_rd_ff <= flist_mem[flist_ra];
   end

   always_ff @(posedge clock) begin
      if (used_we) used_mem[used_wa] <= used_wd;
      if (used_re) used_rd_ff <= used_mem[used_ra];
   end

   always_ff @(posedge clock) begin
      if (queue_we) queue_mem[queue_wa] <= queue_wd;
      if (queue_re) queue_rd_ff <= queue_mem[queue_ra];
   end

   // Checks.
   `ASSERT_ALWAYS(a_node_count, clock, reset, node_count_ff != '0 && node_count_ff <= NCW'(NODES), "node count out of range")
   `ASSERT_ALWAYS(a_found_bound, clock, reset, fcnt_ff <= slot_count_ff, "more found ids than patterns")
   `ASSERT_ALWAYS(a_emit_cap, clock, reset, state_ff != S_K_FD || n_ff < NW'(OUT_CAP), "result cap exceeded")
   `ASSERT_NEXT(a_load_invalidates, clock, reset, state_ff == S_LOAD, !links_valid_ff, "links valid after load")

endmodule
